>>> rtl/atok_pkg.sv
// Shared types and constants for the argument tokenizer.
// Used by the channel interfaces and the top level; depends on nothing.
package atok_pkg;

  localparam int DEFAULT_NUMBER_MAX_LEN = 63;
  localparam int DEFAULT_MAX_ARGS       = 1023;

  localparam int ARG_INDEX_W = 10;
  localparam int INT_W       = 32;

  typedef enum logic [3:0] {
    K_NONE     = 4'd0,
    K_STRCHAR  = 4'd1,
    K_STREND   = 4'd2,
    K_NUMCHAR  = 4'd3,
    K_INTEND   = 4'd4,
    K_FLOATEND = 4'd5,
    K_BADSTART = 4'd6,
    K_BADNUM   = 4'd7,
    K_UNTERM   = 4'd8,
    K_NUMLONG  = 4'd9,
    K_TOOMANY  = 4'd10
  } kind_t;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_LOW_E  = 8'h65;
  localparam logic [7:0] CH_UP_E   = 8'h45;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  localparam logic [INT_W-1:0] MAG_CAP = 32'h8000_0000;
  localparam logic [INT_W-1:0] POS_MAX = 32'h7FFF_FFFF;

endpackage

>>> rtl/atok_if.sv
// Valid/ready channel interfaces for the argument tokenizer.
// Depends on atok_pkg for the result kind type.
interface atok_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_data;

  modport source (output valid, data_byte, end_of_data, input ready);
  modport sink (input valid, data_byte, end_of_data, output ready);
endinterface

interface atok_token_if import atok_pkg::*;;
  logic                     valid;
  logic                     ready;
  kind_t                    kind;
  logic [7:0]               char_value;
  logic signed [INT_W-1:0]  int_value;
  logic [ARG_INDEX_W-1:0]   arg_index;
  logic                     message_done;
  logic                     message_error;

  modport source (output valid, kind, char_value, int_value, arg_index, message_done,
                  message_error, input ready);
  modport sink (input valid, kind, char_value, int_value, arg_index, message_done,
                message_error, output ready);
endinterface

>>> rtl/argument_tokenizer.sv
// Argument tokenizer: splits a byte stream into quoted-string and number arguments.
// Depends on atok_pkg and the channel interfaces in atok_if.sv.
//
// Usage:
//   bytes  : one raw message byte per beat; end_of_data closes the message.
//   tokens : exactly one result beat per input beat, in order.
// Each accepted byte is decoded in the cycle it arrives and its result is
// registered, so a result appears in the cycle after its byte; one byte
// is taken every cycle while tokens is not stalled. The decode is a small
// mode update plus one multiply-by-ten accumulate of the integer value.
// The single result register parts the two sides: a byte is taken while the
// register is empty or while its result is being taken in the same cycle.
// When tokens stalls, the held result stays put and bytes backs up after
// one beat of slack. Errors are sticky until the end-of-data beat, which
// also reports the argument count and returns the block to its reset state.
// Reset (rst, synchronous) clears the mode, counters and flags and drops any
// held result.
module argument_tokenizer
  import atok_pkg::*;
#(
  parameter int NUMBER_MAX_LEN = DEFAULT_NUMBER_MAX_LEN,
  parameter int MAX_ARGS       = DEFAULT_MAX_ARGS
) (
  input  logic           clk,
  input  logic           rst,
  atok_byte_if.sink      bytes,
  atok_token_if.source   tokens
);

  localparam int CNT_W = $clog2(MAX_ARGS + 1);
  localparam int LEN_W = $clog2(NUMBER_MAX_LEN + 1);

  typedef enum logic [2:0] {
    M_NEWARG,
    M_STRING,
    M_ESCAPE,
    M_NUMBER,
    M_ERROR
  } mode_t;

  mode_t             mode, mode_next;
  logic [CNT_W-1:0]  arg_counter, arg_counter_next;
  logic [LEN_W-1:0]  number_length, number_length_next;
  logic              float_seen, float_seen_next;
  logic [INT_W-1:0]  int_accumulator, int_accumulator_next;
  logic              int_negative, int_negative_next;
  logic              int_stopped, int_stopped_next;
  logic              error_flag, error_flag_next;

  logic              out_valid;
  kind_t             kind_next;
  logic [7:0]        char_next;
  logic [INT_W-1:0]  int_next;
  logic [CNT_W-1:0]  index_next;
  logic              done_next;

  logic              take;
  logic [7:0]        c;
  logic              is_digit, is_sep, is_float_ch, num_first, num_any;
  logic [3:0]        digit;
  logic [INT_W+3:0]  acc_cand;
  logic [INT_W-1:0]  acc_take, number_val;

  assign bytes.ready  = !out_valid || tokens.ready;
  assign take         = bytes.valid && bytes.ready;
  assign tokens.valid = out_valid;

  assign c           = bytes.data_byte;
  assign is_digit    = (c >= CH_ZERO) && (c <= CH_NINE);
  assign is_sep      = (c == CH_SPACE) || (c == CH_NUL);
  assign is_float_ch = (c == CH_DOT) || (c == CH_LOW_E) || (c == CH_UP_E);
  assign num_first   = is_digit || (c == CH_MINUS) || (c == CH_PLUS) || (c == CH_DOT);
  assign num_any     = num_first || (c == CH_LOW_E) || (c == CH_UP_E) || (c == CH_COMMA);
  assign digit       = 4'(c - CH_ZERO);

  assign acc_cand = {1'b0, int_accumulator, 3'b000} + {3'b000, int_accumulator, 1'b0}
                    + {(INT_W)'(0), digit};
  assign acc_take = (acc_cand > {4'b0000, MAG_CAP}) ? MAG_CAP : acc_cand[INT_W-1:0];

  always_comb begin
    if (float_seen) begin
      number_val = '0;
    end else if (int_negative) begin
      number_val = (INT_W)'(0) - int_accumulator;
    end else begin
      number_val = int_accumulator[INT_W-1] ? POS_MAX : int_accumulator;
    end
  end

  always_comb begin
    mode_next            = mode;
    arg_counter_next     = arg_counter;
    number_length_next   = number_length;
    float_seen_next      = float_seen;
    int_accumulator_next = int_accumulator;
    int_negative_next    = int_negative;
    int_stopped_next     = int_stopped;
    error_flag_next      = error_flag;
    kind_next            = K_NONE;
    char_next            = '0;
    int_next             = '0;
    index_next           = arg_counter;
    done_next            = 1'b0;

    if (bytes.end_of_data) begin
      done_next = 1'b1;
      unique case (mode)
        M_NUMBER: begin
          kind_next        = float_seen ? K_FLOATEND : K_INTEND;
          int_next         = number_val;
          arg_counter_next = arg_counter + 1'b1;
        end
        M_STRING, M_ESCAPE: begin
          kind_next       = K_UNTERM;
          error_flag_next = 1'b1;
        end
        default: ;
      endcase
      index_next = arg_counter_next;
    end else begin
      unique case (mode)
        M_NEWARG: begin
          if (is_sep) begin
            kind_next = K_NONE;
          end else if ((c == CH_QUOTE) || num_first) begin
            if (arg_counter >= (CNT_W)'(MAX_ARGS)) begin
              kind_next       = K_TOOMANY;
              mode_next       = M_ERROR;
              error_flag_next = 1'b1;
            end else if (c == CH_QUOTE) begin
              mode_next = M_STRING;
            end else begin
              number_length_next   = (LEN_W)'(1);
              float_seen_next      = (c == CH_DOT);
              int_accumulator_next = is_digit ? {(INT_W-4)'(0), digit} : '0;
              int_negative_next    = (c == CH_MINUS);
              int_stopped_next     = !(is_digit || (c == CH_MINUS) || (c == CH_PLUS));
              mode_next            = M_NUMBER;
              kind_next            = K_NUMCHAR;
              char_next            = c;
            end
          end else begin
            kind_next       = K_BADSTART;
            char_next       = c;
            mode_next       = M_ERROR;
            error_flag_next = 1'b1;
          end
        end
        M_STRING: begin
          if (c == CH_BSLASH) begin
            mode_next = M_ESCAPE;
          end else if (c == CH_QUOTE) begin
            kind_next        = K_STREND;
            arg_counter_next = arg_counter + 1'b1;
            mode_next        = M_NEWARG;
          end else begin
            kind_next = K_STRCHAR;
            char_next = c;
          end
        end
        M_ESCAPE: begin
          kind_next = K_STRCHAR;
          char_next = c;
          mode_next = M_STRING;
        end
        M_NUMBER: begin
          if (is_sep) begin
            kind_next        = float_seen ? K_FLOATEND : K_INTEND;
            int_next         = number_val;
            arg_counter_next = arg_counter + 1'b1;
            mode_next        = M_NEWARG;
          end else if (num_any) begin
            if (number_length >= (LEN_W)'(NUMBER_MAX_LEN)) begin
              kind_next       = K_NUMLONG;
              mode_next       = M_ERROR;
              error_flag_next = 1'b1;
            end else begin
              number_length_next = number_length + 1'b1;
              float_seen_next    = float_seen || is_float_ch;
              if (!int_stopped) begin
                if (is_digit) begin
                  int_accumulator_next = acc_take;
                end else begin
                  int_stopped_next = 1'b1;
                end
              end
              kind_next = K_NUMCHAR;
              char_next = c;
            end
          end else begin
            kind_next       = K_BADNUM;
            char_next       = c;
            mode_next       = M_ERROR;
            error_flag_next = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode            <= M_NEWARG;
      arg_counter     <= '0;
      number_length   <= '0;
      float_seen      <= 1'b0;
      int_accumulator <= '0;
      int_negative    <= 1'b0;
      int_stopped     <= 1'b0;
      error_flag      <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (take) begin
        out_valid <= 1'b1;
      end else if (tokens.ready) begin
        out_valid <= 1'b0;
      end
      if (take) begin
        tokens.kind           <= kind_next;
        tokens.char_value     <= char_next;
        tokens.int_value      <= int_next;
        tokens.arg_index      <= (ARG_INDEX_W)'(index_next);
        tokens.message_done   <= done_next;
        tokens.message_error  <= error_flag_next;
        if (bytes.end_of_data) begin
          mode            <= M_NEWARG;
          arg_counter     <= '0;
          number_length   <= '0;
          float_seen      <= 1'b0;
          int_accumulator <= '0;
          int_negative    <= 1'b0;
          int_stopped     <= 1'b0;
          error_flag      <= 1'b0;
        end else begin
          mode            <= mode_next;
          arg_counter     <= arg_counter_next;
          number_length   <= number_length_next;
          float_seen      <= float_seen_next;
          int_accumulator <= int_accumulator_next;
          int_negative    <= int_negative_next;
          int_stopped     <= int_stopped_next;
          error_flag      <= error_flag_next;
        end
      end
    end
  end

endmodule

>>> tb/argument_tokenizer_tb.sv
// Self-checking testbench for argument_tokenizer: directed table, then random messages.
// Predicts every token beat and checks it in order; depends on atok_pkg and atok_if.sv.
`timescale 1ns / 100ps

module argument_tokenizer_tb;
  import atok_pkg::*;

  localparam int NUM_MAX_LEN = DEFAULT_NUMBER_MAX_LEN;
  localparam int ARGS_MAX    = DEFAULT_MAX_ARGS;
  localparam int N_DIRECTED  = 26;
  localparam int PHASE_ITEMS = 200;

  typedef enum logic [2:0] {
    TOK_NEWARG,
    TOK_STRING,
    TOK_ESCAPE,
    TOK_NUMBER,
    TOK_ERROR
  } tok_mode_t;

  typedef struct {
    kind_t                   kind;
    logic [7:0]              char_value;
    logic signed [INT_W-1:0] int_value;
    logic [ARG_INDEX_W-1:0]  arg_index;
    logic                    message_done;
    logic                    message_error;
  } token_t;

  typedef struct {
    logic [7:0] data_byte;
    logic       end_of_data;
    bit         typed;
    token_t     token;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #1 clk = ~clk;

  atok_byte_if  bytes_if ();
  atok_token_if tokens_if ();

  argument_tokenizer #(
    .NUMBER_MAX_LEN(NUM_MAX_LEN),
    .MAX_ARGS(ARGS_MAX)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .bytes(bytes_if),
    .tokens(tokens_if)
  );

  token_t expected_tokens[$];
  int     fail_count = 0;
  int     items_sent = 0;
  int     send_idle_pct = 0;
  int     recv_stall_pct = 0;
  int     send_idle_by_phase [4] = '{0, 78, 0, 14};
  int     recv_stall_by_phase [4] = '{0, 0, 78, 14};

  stim_row_t directed_rows [N_DIRECTED] = '{
    '{8'h00,     1'b1, 1'b1, '{K_NONE,     8'h00,     0,   10'd0, 1'b1, 1'b0}},
    '{CH_SPACE,  1'b0, 1'b1, '{K_NONE,     8'h00,     0,   10'd0, 1'b0, 1'b0}},
    '{CH_NUL,    1'b0, 1'b1, '{K_NONE,     8'h00,     0,   10'd0, 1'b0, 1'b0}},
    '{CH_QUOTE,  1'b0, 1'b1, '{K_NONE,     8'h00,     0,   10'd0, 1'b0, 1'b0}},
    '{8'hFF,     1'b0, 1'b1, '{K_STRCHAR,  8'hFF,     0,   10'd0, 1'b0, 1'b0}},
    '{CH_BSLASH, 1'b0, 1'b1, '{K_NONE,     8'h00,     0,   10'd0, 1'b0, 1'b0}},
    '{CH_QUOTE,  1'b0, 1'b1, '{K_STRCHAR,  CH_QUOTE,  0,   10'd0, 1'b0, 1'b0}},
    '{8'h00,     1'b0, 1'b1, '{K_STRCHAR,  8'h00,     0,   10'd0, 1'b0, 1'b0}},
    '{CH_QUOTE,  1'b0, 1'b1, '{K_STREND,   8'h00,     0,   10'd0, 1'b0, 1'b0}},
    '{CH_MINUS,  1'b0, 1'b1, '{K_NUMCHAR,  CH_MINUS,  0,   10'd1, 1'b0, 1'b0}},
    '{"9",       1'b0, 1'b0, '{K_NONE,     8'h00,     0,   10'd0, 1'b0, 1'b0}},
    '{CH_SPACE,  1'b0, 1'b1, '{K_INTEND,   8'h00,     -9,  10'd1, 1'b0, 1'b0}},
    '{CH_DOT,    1'b0, 1'b0, '{K_NONE,     8'h00,     0,   10'd0, 1'b0, 1'b0}},
    '{CH_LOW_E,  1'b0, 1'b0, '{K_NONE,     8'h00,     0,   10'd0, 1'b0, 1'b0}},
    '{8'hA5,     1'b1, 1'b1, '{K_FLOATEND, 8'h00,     0,   10'd3, 1'b1, 1'b0}},
    '{"a",       1'b0, 1'b1, '{K_BADSTART, "a",       0,   10'd0, 1'b0, 1'b1}},
    '{"1",       1'b0, 1'b0, '{K_NONE,     8'h00,     0,   10'd0, 1'b0, 1'b0}},
    '{8'hFF,     1'b1, 1'b1, '{K_NONE,     8'h00,     0,   10'd0, 1'b1, 1'b1}},
    '{CH_QUOTE,  1'b0, 1'b0, '{K_NONE,     8'h00,     0,   10'd0, 1'b0, 1'b0}},
    '{CH_BSLASH, 1'b0, 1'b0, '{K_NONE,     8'h00,     0,   10'd0, 1'b0, 1'b0}},
    '{8'h00,     1'b1, 1'b1, '{K_UNTERM,   8'h00,     0,   10'd0, 1'b1, 1'b1}},
    '{"7",       1'b0, 1'b0, '{K_NONE,     8'h00,     0,   10'd0, 1'b0, 1'b0}},
    '{CH_PLUS,   1'b0, 1'b0, '{K_NONE,     8'h00,     0,   10'd0, 1'b0, 1'b0}},
    '{CH_COMMA,  1'b0, 1'b0, '{K_NONE,     8'h00,     0,   10'd0, 1'b0, 1'b0}},
    '{"x",       1'b0, 1'b1, '{K_BADNUM,   "x",       0,   10'd0, 1'b0, 1'b1}},
    '{8'h3C,     1'b1, 1'b0, '{K_NONE,     8'h00,     0,   10'd0, 1'b0, 1'b0}}
  };

  tok_mode_t        tok_mode;
  int unsigned      arg_count;
  int unsigned      num_len;
  bit               num_float;
  logic [INT_W-1:0] num_mag;
  bit               num_neg;
  bit               num_stopped;
  bit               msg_err;

  function automatic void clear_number();
    num_len     = 0;
    num_float   = 1'b0;
    num_mag     = '0;
    num_neg     = 1'b0;
    num_stopped = 1'b0;
  endfunction

  function automatic void reset_tokenizer();
    tok_mode  = TOK_NEWARG;
    arg_count = 0;
    msg_err   = 1'b0;
    clear_number();
  endfunction

  function automatic bit is_number_byte(input logic [7:0] c, input bit first);
    if (c >= CH_ZERO && c <= CH_NINE) return 1'b1;
    if (c == CH_MINUS || c == CH_PLUS || c == CH_DOT) return 1'b1;
    return !first && (c == CH_LOW_E || c == CH_UP_E || c == CH_COMMA);
  endfunction

  function automatic void accumulate_number(input logic [7:0] c, input bit first);
    logic [INT_W-1:0] digit;
    if (c == CH_DOT || c == CH_LOW_E || c == CH_UP_E) num_float = 1'b1;
    if (num_stopped) return;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      digit = {24'd0, c - CH_ZERO};
      if (num_mag > (MAG_CAP - digit) / 10) num_mag = MAG_CAP;
      else num_mag = num_mag * 10 + digit;
    end else if (first && (c == CH_MINUS || c == CH_PLUS)) begin
      num_neg = (c == CH_MINUS);
    end else begin
      num_stopped = 1'b1;
    end
  endfunction

  function automatic void close_number(inout token_t t);
    t.kind = num_float ? K_FLOATEND : K_INTEND;
    if (num_float) t.int_value = '0;
    else if (num_neg) t.int_value = 32'd0 - num_mag;
    else t.int_value = (num_mag >= MAG_CAP) ? POS_MAX : num_mag;
    arg_count++;
  endfunction

  function automatic kind_t flag_error(input kind_t k);
    msg_err  = 1'b1;
    tok_mode = TOK_ERROR;
    return k;
  endfunction

  function automatic token_t tokenize_byte(input logic [7:0] c, input logic eod);
    token_t t;
    t = '{K_NONE, 8'h00, '0, arg_count[ARG_INDEX_W-1:0], 1'b0, 1'b0};
    if (eod) begin
      t.message_done = 1'b1;
      if (tok_mode == TOK_NUMBER) close_number(t);
      else if (tok_mode == TOK_STRING || tok_mode == TOK_ESCAPE) t.kind = flag_error(K_UNTERM);
      t.arg_index = arg_count[ARG_INDEX_W-1:0];
    end else begin
      case (tok_mode)
        TOK_NEWARG: begin
          if (c == CH_QUOTE || is_number_byte(c, 1'b1)) begin
            if (arg_count >= ARGS_MAX) begin
              t.kind = flag_error(K_TOOMANY);
            end else if (c == CH_QUOTE) begin
              tok_mode = TOK_STRING;
            end else begin
              clear_number();
              num_len = 1;
              accumulate_number(c, 1'b1);
              tok_mode     = TOK_NUMBER;
              t.kind       = K_NUMCHAR;
              t.char_value = c;
            end
          end else if (c != CH_SPACE && c != CH_NUL) begin
            t.kind       = flag_error(K_BADSTART);
            t.char_value = c;
          end
        end
        TOK_STRING: begin
          if (c == CH_BSLASH) begin
            tok_mode = TOK_ESCAPE;
          end else if (c == CH_QUOTE) begin
            t.kind = K_STREND;
            arg_count++;
            tok_mode = TOK_NEWARG;
          end else begin
            t.kind       = K_STRCHAR;
            t.char_value = c;
          end
        end
        TOK_ESCAPE: begin
          t.kind       = K_STRCHAR;
          t.char_value = c;
          tok_mode     = TOK_STRING;
        end
        TOK_NUMBER: begin
          if (c == CH_SPACE || c == CH_NUL) begin
            close_number(t);
            tok_mode = TOK_NEWARG;
          end else if (is_number_byte(c, 1'b0)) begin
            if (num_len >= NUM_MAX_LEN) begin
              t.kind = flag_error(K_NUMLONG);
            end else begin
              num_len++;
              accumulate_number(c, 1'b0);
              t.kind       = K_NUMCHAR;
              t.char_value = c;
            end
          end else begin
            t.kind       = flag_error(K_BADNUM);
            t.char_value = c;
          end
        end
        default: begin
        end
      endcase
    end
    t.message_error = msg_err;
    if (eod) reset_tokenizer();
    return t;
  endfunction

  task automatic send_byte(input logic [7:0] c, input logic eod);
    while ($urandom_range(99) < send_idle_pct) begin
      bytes_if.valid <= 1'b0;
      @(posedge clk);
    end
    bytes_if.valid       <= 1'b1;
    bytes_if.data_byte   <= c;
    bytes_if.end_of_data <= eod;
    @(posedge clk);
    while (!bytes_if.ready) @(posedge clk);
    expected_tokens.push_back(tokenize_byte(c, eod));
    items_sent++;
  endtask

  task automatic send_gap(input int min_len);
    repeat ($urandom_range(2, min_len)) send_byte($urandom_range(1) ? CH_SPACE : CH_NUL, 1'b0);
  endtask

  task automatic send_string(input bit closed);
    logic [7:0] c;
    send_byte(CH_QUOTE, 1'b0);
    repeat ($urandom_range(8)) begin
      c = 8'($urandom_range(255));
      if (c == CH_QUOTE || c == CH_BSLASH || $urandom_range(9) == 0) send_byte(CH_BSLASH, 1'b0);
      send_byte(c, 1'b0);
    end
    if (closed) send_byte(CH_QUOTE, 1'b0);
    else if ($urandom_range(1)) send_byte(CH_BSLASH, 1'b0);
  endtask

  task automatic send_number();
    int         n;
    int         r;
    logic [7:0] c;
    r = $urandom_range(99);
    n = (r < 6) ? $urandom_range(68, 60) : (r < 30) ? $urandom_range(12, 9) : $urandom_range(5, 1);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < ((i == 0) ? 25 : 4)) begin
        c = $urandom_range(1) ? CH_MINUS : CH_PLUS;
      end else if (r < ((i == 0) ? 30 : 10)) begin
        case ($urandom_range(3))
          0: c = CH_DOT;
          1: c = CH_LOW_E;
          2: c = CH_UP_E;
          default: c = CH_COMMA;
        endcase
      end else begin
        c = CH_ZERO + 8'($urandom_range(9));
      end
      send_byte(c, 1'b0);
    end
  endtask

  task automatic send_message();
    int         shape;
    int         nargs;
    logic [7:0] c;
    shape = $urandom_range(99);
    send_gap(0);
    if (shape < 80) begin
      nargs = $urandom_range(6, 1);
      for (int a = 0; a < nargs; a++) begin
        if ($urandom_range(1)) begin
          send_string(1'b1);
          send_gap(0);
        end else begin
          send_number();
          if (a < nargs - 1 || $urandom_range(1)) send_gap(1);
        end
      end
    end else if (shape < 88) begin
      send_number();
      do c = 8'($urandom_range(255));
      while (is_number_byte(c, 1'b0) || c == CH_SPACE || c == CH_NUL);
      send_byte(c, 1'b0);
    end else if (shape < 94) begin
      send_string(1'b0);
    end else begin
      repeat ($urandom_range(8, 1)) send_byte(8'($urandom_range(255)), 1'b0);
    end
    send_byte(8'($urandom_range(255)), 1'b1);
  endtask

  initial begin
    token_t want;
    tokens_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && tokens_if.valid && tokens_if.ready) begin
        if (expected_tokens.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected token beat: kind %0d char %h int %0d idx %0d",
                     tokens_if.kind, tokens_if.char_value, tokens_if.int_value,
                     tokens_if.arg_index);
        end else begin
          want = expected_tokens.pop_front();
          if (tokens_if.kind !== want.kind || tokens_if.char_value !== want.char_value ||
              tokens_if.int_value !== want.int_value ||
              tokens_if.arg_index !== want.arg_index ||
              tokens_if.message_done !== want.message_done ||
              tokens_if.message_error !== want.message_error) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("token mismatch: expected kind %0d char %h int %0d idx %0d done %b err %b",
                       want.kind, want.char_value, want.int_value, want.arg_index,
                       want.message_done, want.message_error);
              $display("                got      kind %0d char %h int %0d idx %0d done %b err %b",
                       tokens_if.kind, tokens_if.char_value, tokens_if.int_value,
                       tokens_if.arg_index, tokens_if.message_done, tokens_if.message_error);
            end
          end
        end
      end
      tokens_if.ready <= !rst && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    int phase_start;
    bytes_if.valid       <= 1'b0;
    bytes_if.data_byte   <= 8'h00;
    bytes_if.end_of_data <= 1'b0;
    reset_tokenizer();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      send_byte(directed_rows[i].data_byte, directed_rows[i].end_of_data);
      if (directed_rows[i].typed)
        expected_tokens[expected_tokens.size() - 1] = directed_rows[i].token;
    end

    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = send_idle_by_phase[p];
      recv_stall_pct = recv_stall_by_phase[p];
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) send_message();
    end
    bytes_if.valid <= 1'b0;

    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #500_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
